[hw/rtl/dbhs_pkg.sv]
// shared types, codes and defaults for the depth buffer hidden surface unit
`default_nettype none

package dbhs_pkg;

    localparam int MAX_ROWS_DEF    = 256;
    localparam int MAX_COLUMNS_DEF = 256;
    localparam int DEPTH_BITS_DEF  = 16;

    localparam int COLOR_W = 24;
    localparam int QDEPTH  = 2;
    localparam int QPW     = 1;

    localparam logic [1:0] MODE_CLEAR    = 2'd0;
    localparam logic [1:0] MODE_FRAGMENT = 2'd1;
    localparam logic [1:0] MODE_READ     = 2'd2;

    localparam logic [1:0] REG_CLEAR_DEPTH    = 2'd0;
    localparam logic [1:0] REG_ACTIVE_ROWS    = 2'd1;
    localparam logic [1:0] REG_ACTIVE_COLUMNS = 2'd2;

    localparam logic [15:0] CLEAR_DEPTH_RST    = 16'd255;
    localparam logic [8:0]  ACTIVE_ROWS_RST    = 9'd256;
    localparam logic [8:0]  ACTIVE_COLUMNS_RST = 9'd256;

    typedef enum logic [1:0] {
        K_CLEAR,
        K_FRAG,
        K_READ,
        K_NULL
    } op_kind_t;

    typedef struct packed {
        logic        valid;
        op_kind_t    kind;
    } q_head_t;

    typedef struct packed {
        logic [15:0] clear_depth;
        logic [8:0]  active_rows;
        logic [8:0]  active_columns;
    } cfg_t;

endpackage

`default_nettype wire

[hw/rtl/depth_buffer_hidden_surface_unit.sv]
// top level of the z-buffer depth test unit
// a read or fragment word is popped from the queue head with a store read,
// then compare and write; the back end takes no new word until the compare has run,
// which waits while m_tready holds the output; the depth store read is registered
// a clear writes rows_eff * cols_eff pixels, one pixel per cycle
// reset loads clear_depth 255 and 256 rows and columns; the stores are not
// cleared, their contents are undefined until a clear word has run
`default_nettype none

module depth_buffer_hidden_surface_unit #(
    parameter int MAX_ROWS    = dbhs_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLUMNS = dbhs_pkg::MAX_COLUMNS_DEF,
    parameter int DEPTH_BITS  = dbhs_pkg::DEPTH_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wen,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // pixel_row, pixel_column, fragment_depth, fragment_color
    input  wire logic [1:0]  s_tuser,   // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata    // passed, stored_depth, stored_color, zero pad
);

    import dbhs_pkg::*;

    localparam int PIXELS = MAX_ROWS * MAX_COLUMNS;
    localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int RCW    = ($clog2(MAX_ROWS + 1) > 9) ? $clog2(MAX_ROWS + 1) : 9;
    localparam int CCW    = ($clog2(MAX_COLUMNS + 1) > 9) ? $clog2(MAX_COLUMNS + 1) : 9;

    q_head_t               head;
    logic [AW-1:0]         head_addr;
    logic [DEPTH_BITS-1:0] head_depth;
    logic [COLOR_W-1:0]    head_color;
    logic                  head_pop;
    logic [RCW-1:0]        rows_eff;
    logic [CCW-1:0]        cols_eff;
    logic [DEPTH_BITS-1:0] clear_depth_m;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DEPTH_BITS-1:0] mem_wdepth;
    logic [COLOR_W-1:0]    mem_wcolor;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [DEPTH_BITS-1:0] mem_rdepth;
    logic [COLOR_W-1:0]    mem_rcolor;

    dbhs_front #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .DEPTH_BITS  (DEPTH_BITS),
        .AW          (AW),
        .RCW         (RCW),
        .CCW         (CCW)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .head          (head),
        .head_addr     (head_addr),
        .head_depth    (head_depth),
        .head_color    (head_color),
        .head_pop      (head_pop),
        .rows_eff      (rows_eff),
        .cols_eff      (cols_eff),
        .clear_depth_m (clear_depth_m)
    );

    dbhs_back #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .DEPTH_BITS  (DEPTH_BITS),
        .AW          (AW),
        .RCW         (RCW),
        .CCW         (CCW)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_addr     (head_addr),
        .head_depth    (head_depth),
        .head_color    (head_color),
        .head_pop      (head_pop),
        .rows_eff      (rows_eff),
        .cols_eff      (cols_eff),
        .clear_depth_m (clear_depth_m),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdepth    (mem_wdepth),
        .mem_wcolor    (mem_wcolor),
        .mem_re        (mem_re),
        .mem_raddr     (mem_raddr),
        .mem_rdepth    (mem_rdepth),
        .mem_rcolor    (mem_rcolor),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

    dbhs_ram #(
        .WIDTH (DEPTH_BITS),
        .DEPTH (PIXELS),
        .AW    (AW)
    ) u_depth_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdepth),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdepth)
    );

    dbhs_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PIXELS),
        .AW    (AW)
    ) u_color_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wcolor),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rcolor)
    );

endmodule

`default_nettype wire

[hw/rtl/dbhs_ram.sv]
// generic simple dual port ram with registered read
`default_nettype none

module dbhs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/dbhs_front.sv]
// front end: config registers, input classification and command queue
`default_nettype none

module dbhs_front #(
    parameter int MAX_ROWS    = dbhs_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLUMNS = dbhs_pkg::MAX_COLUMNS_DEF,
    parameter int DEPTH_BITS  = dbhs_pkg::DEPTH_BITS_DEF,
    parameter int AW          = ((MAX_ROWS * MAX_COLUMNS) > 1) ?
                                $clog2(MAX_ROWS * MAX_COLUMNS) : 1,
    parameter int RCW         = ($clog2(MAX_ROWS + 1) > 9) ? $clog2(MAX_ROWS + 1) : 9,
    parameter int CCW         = ($clog2(MAX_COLUMNS + 1) > 9) ? $clog2(MAX_COLUMNS + 1) : 9
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_wen,
    input  wire logic [1:0]              cfg_index,
    input  wire logic [15:0]             cfg_wdata,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [55:0]             s_tdata,
    input  wire logic [1:0]              s_tuser,
    output dbhs_pkg::q_head_t            head,
    output logic      [AW-1:0]           head_addr,
    output logic      [DEPTH_BITS-1:0]   head_depth,
    output logic      [23:0]             head_color,
    input  wire logic                    head_pop,
    output logic      [RCW-1:0]          rows_eff,
    output logic      [CCW-1:0]          cols_eff,
    output logic      [DEPTH_BITS-1:0]   clear_depth_m
);

    import dbhs_pkg::*;

    cfg_t cfg_reg;

    op_kind_t        q_kind_reg  [QDEPTH];
    logic [AW-1:0]   q_addr_reg  [QDEPTH];
    logic [DEPTH_BITS-1:0] q_depth_reg [QDEPTH];
    logic [COLOR_W-1:0]    q_color_reg [QDEPTH];
    logic [QPW-1:0]  wr_ptr_reg;
    logic [QPW-1:0]  rd_ptr_reg;
    logic [QPW:0]    count_reg;

    logic [7:0]      in_row;
    logic [7:0]      in_col;
    logic [DEPTH_BITS-1:0] in_depth;
    logic [COLOR_W-1:0]    in_color;
    logic            in_win;
    logic            accept;
    op_kind_t        kind_c;
    logic [AW-1:0]   addr_c;

    assign in_row   = s_tdata[7:0];
    assign in_col   = s_tdata[15:8];
    assign in_depth = DEPTH_BITS'(s_tdata[31:16]);
    assign in_color = s_tdata[55:32];

    assign rows_eff = (RCW'(cfg_reg.active_rows) > RCW'(MAX_ROWS)) ?
                      RCW'(MAX_ROWS) : RCW'(cfg_reg.active_rows);
    assign cols_eff = (CCW'(cfg_reg.active_columns) > CCW'(MAX_COLUMNS)) ?
                      CCW'(MAX_COLUMNS) : CCW'(cfg_reg.active_columns);
    assign clear_depth_m = DEPTH_BITS'(cfg_reg.clear_depth);

    assign in_win = (RCW'(in_row) < rows_eff) && (CCW'(in_col) < cols_eff);
    assign addr_c = AW'(in_row) * AW'(MAX_COLUMNS) + AW'(in_col);

    always_comb
    begin
        unique case (s_tuser) inside
            MODE_CLEAR:
                kind_c = K_CLEAR;
            MODE_FRAGMENT, MODE_READ:
                kind_c = !in_win ? K_NULL : ((s_tuser == MODE_FRAGMENT) ? K_FRAG : K_READ);
            default:
                kind_c = K_NULL;
        endcase
    end

    assign s_tready = (count_reg != (QPW + 1)'(QDEPTH));
    assign accept   = s_tvalid && s_tready;

    assign head.valid = (count_reg != '0);
    assign head.kind  = q_kind_reg[rd_ptr_reg];
    assign head_addr  = q_addr_reg[rd_ptr_reg];
    assign head_depth = q_depth_reg[rd_ptr_reg];
    assign head_color = q_color_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clear_depth    <= CLEAR_DEPTH_RST;
            cfg_reg.active_rows    <= ACTIVE_ROWS_RST;
            cfg_reg.active_columns <= ACTIVE_COLUMNS_RST;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_CLEAR_DEPTH:    cfg_reg.clear_depth    <= cfg_wdata;
                REG_ACTIVE_ROWS:    cfg_reg.active_rows    <= cfg_wdata[8:0];
                REG_ACTIVE_COLUMNS: cfg_reg.active_columns <= cfg_wdata[8:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (head_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (accept && !head_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!accept && head_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_kind_reg[wr_ptr_reg]  <= kind_c;
            q_addr_reg[wr_ptr_reg]  <= addr_c;
            q_depth_reg[wr_ptr_reg] <= in_depth;
            q_color_reg[wr_ptr_reg] <= in_color;
        end
    end

`ifndef SYNTH
    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |-> (count_reg != '0))
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == (QPW + 1)'(QDEPTH)) |=> (count_reg != '0))
        else $error("queue count lost while full");
`endif

endmodule

`default_nettype wire

[hw/rtl/dbhs_back.sv]
// back end: clear walk, store reads and depth test read-modify-write on the pixel stores
`default_nettype none

module dbhs_back #(
    parameter int MAX_ROWS    = dbhs_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLUMNS = dbhs_pkg::MAX_COLUMNS_DEF,
    parameter int DEPTH_BITS  = dbhs_pkg::DEPTH_BITS_DEF,
    parameter int AW          = ((MAX_ROWS * MAX_COLUMNS) > 1) ?
                                $clog2(MAX_ROWS * MAX_COLUMNS) : 1,
    parameter int RCW         = ($clog2(MAX_ROWS + 1) > 9) ? $clog2(MAX_ROWS + 1) : 9,
    parameter int CCW         = ($clog2(MAX_COLUMNS + 1) > 9) ? $clog2(MAX_COLUMNS + 1) : 9
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dbhs_pkg::q_head_t     head,
    input  wire logic [AW-1:0]         head_addr,
    input  wire logic [DEPTH_BITS-1:0] head_depth,
    input  wire logic [23:0]           head_color,
    output logic                       head_pop,
    input  wire logic [RCW-1:0]        rows_eff,
    input  wire logic [CCW-1:0]        cols_eff,
    input  wire logic [DEPTH_BITS-1:0] clear_depth_m,
    output logic                       mem_we,
    output logic      [AW-1:0]         mem_waddr,
    output logic      [DEPTH_BITS-1:0] mem_wdepth,
    output logic      [23:0]           mem_wcolor,
    output logic                       mem_re,
    output logic      [AW-1:0]         mem_raddr,
    input  wire logic [DEPTH_BITS-1:0] mem_rdepth,
    input  wire logic [23:0]           mem_rcolor,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [47:0]           m_tdata
);

    import dbhs_pkg::*;

    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLEAR,
        S_EVAL
    } state_t;

    state_t                state_reg, state_next;
    op_kind_t              op_reg, op_next;
    logic [AW-1:0]         addr_reg, addr_next;
    logic [DEPTH_BITS-1:0] fdepth_reg, fdepth_next;
    logic [COLOR_W-1:0]    fcolor_reg, fcolor_next;
    logic [RW-1:0]         r_reg, r_next;
    logic [CW-1:0]         c_reg, c_next;
    logic                  done_reg, done_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [47:0]           m_tdata_reg, m_tdata_next;

    logic                  out_free;
    logic                  out_load;
    logic                  o_pass;
    logic [DEPTH_BITS-1:0] o_depth;
    logic [COLOR_W-1:0]    o_color;
    logic                  pass_c;
    logic [AW-1:0]         clear_addr;
    logic [RW-1:0]         last_r;
    logic [CW-1:0]         last_c;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign pass_c     = (op_reg == K_FRAG) && (fdepth_reg < mem_rdepth);
    assign clear_addr = AW'(r_reg) * AW'(MAX_COLUMNS) + AW'(c_reg);
    assign last_r     = RW'(rows_eff - 1'b1);
    assign last_c     = CW'(cols_eff - 1'b1);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        addr_next   = addr_reg;
        fdepth_next = fdepth_reg;
        fcolor_next = fcolor_reg;
        r_next      = r_reg;
        c_next      = c_reg;
        done_next   = done_reg;
        head_pop    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = addr_reg;
        mem_wdepth  = fdepth_reg;
        mem_wcolor  = fcolor_reg;
        mem_re      = 1'b0;
        mem_raddr   = head_addr;
        out_load    = 1'b0;
        o_pass      = 1'b0;
        o_depth     = '0;
        o_color     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    op_next     = head.kind;
                    addr_next   = head_addr;
                    fdepth_next = head_depth;
                    fcolor_next = head_color;
                    unique case (head.kind)
                        K_CLEAR:
                        begin
                            head_pop   = 1'b1;
                            r_next     = '0;
                            c_next     = '0;
                            done_next  = (rows_eff == '0) || (cols_eff == '0);
                            state_next = S_CLEAR;
                        end
                        K_FRAG, K_READ:
                        begin
                            head_pop   = 1'b1;
                            mem_re     = 1'b1;
                            state_next = S_EVAL;
                        end
                        default:
                        begin
                            if (out_free)
                            begin
                                head_pop = 1'b1;
                                out_load = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                if (done_reg)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        o_depth    = clear_depth_m;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = clear_addr;
                    mem_wdepth = clear_depth_m;
                    mem_wcolor = '0;
                    if (c_reg == last_c)
                    begin
                        c_next = '0;
                        if (r_reg == last_r)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            r_next = r_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        c_next = c_reg + 1'b1;
                    end
                end
            end
            S_EVAL:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    o_pass     = pass_c;
                    mem_we     = pass_c;
                    o_depth    = pass_c ? fdepth_reg : mem_rdepth;
                    o_color    = pass_c ? fcolor_reg : mem_rcolor;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {7'd0, o_color, 16'(o_depth), o_pass};
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg && !m_tready;
            m_tdata_next  = m_tdata_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= done_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        addr_reg    <= addr_next;
        fdepth_reg  <= fdepth_next;
        fcolor_reg  <= fcolor_next;
        r_reg       <= r_next;
        c_reg       <= c_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR || state_reg == S_EVAL))
        else $error("store written outside clear or test");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |-> (state_reg == S_IDLE))
        else $error("queue popped while busy");

    a_pass_frag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && o_pass) |-> (state_reg == S_EVAL && op_reg == K_FRAG))
        else $error("pass reported for a non fragment word");

    a_eval_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> ($past(mem_re) || $past(state_reg) == S_EVAL))
        else $error("depth test without a store read");
`endif

endmodule

`default_nettype wire
